// ===== src/pcm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_pkg
// shared widths, register map and reset values of the pixel contrast map
// ----------------------------------------------------------------------------
package pcm_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 12;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 1;
  localparam int ADDR_W    = REG_IDX_W + 2;

  localparam logic [REG_IDX_W-1:0] REG_LINE_WIDTH   = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 12'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage
`default_nettype wire

// ===== src/pixel_contrast_map_with_frame_max.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_contrast_map_with_frame_max
// backward-difference contrast of a raster pixel stream with frame maximum
// ----------------------------------------------------------------------------
// Takes one 8-bit gray pixel per clock in raster order, unless in_stall is
// high, and returns, for each pixel, the larger of its absolute differences
// to the left neighbour and to the pixel above (left difference is 0 in the
// first column, upper difference 0 in the first row), plus the running
// maximum of that contrast over the frame and a frame_done flag on the
// frame's last pixel. A result beat passes the stage register, then the
// output register, which holds it while out_stall is high.
// Throughput is set by the single line-store memory port, which reads the
// pixel above and writes the current pixel at the same address in the same
// clock (read-first), so no forwarding path is needed even for one-pixel
// rows. The line store is not cleared: it is always written one row before
// it is read. frame_start restarts the column, row and maximum; after the
// last pixel of a frame they restart on their own. line_width and
// frame_height (APB at 0x0 and 0x4) take effect for the next pixel; 0 acts
// as 1 and values above MAX_WIDTH / MAX_HEIGHT saturate. Write them only
// while the block is idle.
// ----------------------------------------------------------------------------
module pixel_contrast_map_with_frame_max #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire                                   clk,
  input  wire                                   rst,
  // apb configuration port
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire  [pcm_pkg::ADDR_W-1:0]            paddr,
  input  wire  [pcm_pkg::DATA_W-1:0]            pwdata,
  output logic [pcm_pkg::DATA_W-1:0]            prdata,
  output logic                                  pready,
  // pixel input
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  [pcm_pkg::PIX_W-1:0]             pixel,
  input  wire                                   frame_start,
  // contrast output
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic [pcm_pkg::PIX_W-1:0]             contrast,
  output logic [pcm_pkg::PIX_W-1:0]             frame_max,
  output logic                                  frame_done
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int EW0 = (WW > HW) ? WW : HW;
  localparam int EW  = ((EW0 > pcm_pkg::CFG_W) ? EW0 : pcm_pkg::CFG_W) + 1;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [pcm_pkg::CFG_W-1:0]     line_width;
  logic [pcm_pkg::CFG_W-1:0]     frame_height;
  logic [pcm_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[pcm_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= pcm_pkg::LINE_WIDTH_RST;
      frame_height <= pcm_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        pcm_pkg::REG_LINE_WIDTH:   line_width   <= pwdata[pcm_pkg::CFG_W-1:0];
        pcm_pkg::REG_FRAME_HEIGHT: frame_height <= pwdata[pcm_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pcm_pkg::REG_LINE_WIDTH:
        prdata = {{(pcm_pkg::DATA_W-pcm_pkg::CFG_W){1'b0}}, line_width};
      pcm_pkg::REG_FRAME_HEIGHT:
        prdata = {{(pcm_pkg::DATA_W-pcm_pkg::CFG_W){1'b0}}, frame_height};
      default:
        prdata = '0;
    endcase
  end

  // last column / last row index after clamping (0 acts as 1, saturate high)
  logic [EW-1:0] w_last;
  logic [EW-1:0] h_last;

  always_comb begin
    priority if (line_width == '0)
      w_last = '0;
    else if (EW'(line_width) > EW'(MAX_WIDTH))
      w_last = EW'(MAX_WIDTH - 1);
    else
      w_last = EW'(line_width) - EW'(1);

    priority if (frame_height == '0)
      h_last = '0;
    else if (EW'(frame_height) > EW'(MAX_HEIGHT))
      h_last = EW'(MAX_HEIGHT - 1);
    else
      h_last = EW'(frame_height) - EW'(1);
  end

  // --------------------------------------------------------------------------
  // pipeline handshake: stage 1 holds the pixel and the line-store read,
  // the output register holds the finished beat
  // --------------------------------------------------------------------------
  logic s1_valid;
  logic s1_adv;
  logic in_acc;

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // stage 0: raster position, line-store read-modify-write
  // --------------------------------------------------------------------------
  logic [CW-1:0]            column_count;
  logic [RW-1:0]            row_count;
  logic [pcm_pkg::PIX_W-1:0] left_pixel;

  logic [CW-1:0] col_cur;
  logic [RW-1:0] row_cur;
  logic          last_col;
  logic          last_row;
  logic [CW-1:0] column_count_next;
  logic [RW-1:0] row_count_next;

  assign col_cur  = frame_start ? '0 : column_count;
  assign row_cur  = frame_start ? '0 : row_count;
  assign last_col = EW'(col_cur) >= w_last;
  assign last_row = EW'(row_cur) >= h_last;

  always_comb begin
    column_count_next = last_col ? '0 : col_cur + CW'(1);
    row_count_next    = row_cur;
    if (last_col) begin
      row_count_next = last_row ? '0 : row_cur + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      left_pixel   <= '0;
    end else if (in_acc) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      left_pixel   <= pixel;
    end
  end

  // line store: read-first, so the old entry (pixel above) is read while the
  // current pixel overwrites it in the same clock
  logic [pcm_pkg::PIX_W-1:0] row_store [MAX_WIDTH];
  logic [pcm_pkg::PIX_W-1:0] above;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      above            <= row_store[col_cur];
      row_store[col_cur] <= pixel;
    end
  end

  // stage 1 payload
  logic [pcm_pkg::PIX_W-1:0] s1_pixel;
  logic [pcm_pkg::PIX_W-1:0] s1_left;
  logic                      s1_first_col;
  logic                      s1_first_row;
  logic                      s1_done;
  logic                      s1_clear;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pixel     <= pixel;
      s1_left      <= left_pixel;
      s1_first_col <= (col_cur == '0);
      s1_first_row <= (row_cur == '0);
      s1_done      <= last_col && last_row;
      s1_clear     <= frame_start;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: differences, contrast and running maximum
  // --------------------------------------------------------------------------
  logic [pcm_pkg::PIX_W-1:0] running_max;
  logic [pcm_pkg::PIX_W-1:0] dx;
  logic [pcm_pkg::PIX_W-1:0] dy;
  logic [pcm_pkg::PIX_W-1:0] c_val;
  logic [pcm_pkg::PIX_W-1:0] max_base;
  logic [pcm_pkg::PIX_W-1:0] running_max_next;

  assign dx       = s1_first_col ? '0 : pcm_pkg::abs_diff(s1_pixel, s1_left);
  assign dy       = s1_first_row ? '0 : pcm_pkg::abs_diff(s1_pixel, above);
  assign c_val    = (dx > dy) ? dx : dy;
  assign max_base = s1_clear ? '0 : running_max;
  assign running_max_next = (c_val > max_base) ? c_val : max_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max <= '0;
    end else if (s1_adv) begin
      // the maximum restarts after the last pixel of a frame
      running_max <= s1_done ? '0 : running_max_next;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      contrast   <= c_val;
      frame_max  <= running_max_next;
      frame_done <= s1_done;
    end
  end

endmodule
`default_nettype wire

// ===== src/pcm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_port_checks
// port-level checks of the pixel contrast map
// ----------------------------------------------------------------------------
module pcm_port_checks (
  input wire                        clk,
  input wire                        rst,
  input wire                        in_stall,
  input wire                        out_valid,
  input wire                        out_stall,
  input wire [pcm_pkg::PIX_W-1:0]   contrast,
  input wire [pcm_pkg::PIX_W-1:0]   frame_max
);

  // a held output beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  // the frame maximum covers the contrast of the same beat
  a_max_covers: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_max >= contrast)
    else $error("frame_max below contrast");

  // input is only held back when the output side is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind pixel_contrast_map_with_frame_max pcm_port_checks u_pcm_port_checks (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .contrast  (contrast),
  .frame_max (frame_max)
);
`default_nettype wire
